@@ sv/sst_pkg.sv @@
// Package for the sorted set table: sizes, command codes and the structs
// passed between the cells, the reduce tree and the top level.
// No dependencies.
`default_nettype none

package sst_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_BITS = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int GRP_SZ = 16;
    localparam int NGRP = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_ERASE    = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_GET      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED1,
        ST_RED2,
        ST_APPLY
    } t_state;

    // Update strobes broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic era;
    } t_ctl;

    // What a cell shows its neighbors.
    typedef struct packed {
        t_key key;
        logic valid;
        logic p;    // at or past the insert slot
        logic ge;   // valid and key >= search key
    } t_link;

    // Reduced search result.
    typedef struct packed {
        logic found;
        logic hit;
        t_key data;
    } t_red;

endpackage

`default_nettype wire

@@ sv/sst_if.sv @@
// Handshake channels of the sorted set table: command in, result out.
// Depends on sst_pkg.
`default_nettype none

interface sst_cmd_if;
    logic              valid;
    logic              ready;
    sst_pkg::t_cmd     command;
    logic [31:0]       key;
    logic [7:0]        position;

    modport source (output valid, command, key, position, input ready);
    modport sink (input valid, command, key, position, output ready);
endinterface

interface sst_res_if;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [31:0]       read_key;
    logic [8:0]        count;
    logic              is_empty;

    modport source (output valid, ok, read_key, count, is_empty, input ready);
    modport sink (input valid, ok, read_key, count, is_empty, output ready);
endinterface

`default_nettype wire

@@ sv/sst_cell.sv @@
// One slot of the sorted table: holds a key and its valid bit, compares
// against the broadcast key and shifts to or from its neighbors. Uses sst_pkg.
`default_nettype none

module sst_cell (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  sst_pkg::t_idx      i_index,
    input  sst_pkg::t_key      i_key,
    input  wire  [7:0]         i_pos,
    input  sst_pkg::t_ctl      i_ctl,
    input  sst_pkg::t_link     i_prev,
    input  sst_pkg::t_link     i_next,
    output sst_pkg::t_link     o_link,
    output logic               o_eq,
    output logic               o_sel,
    output sst_pkg::t_key      o_data
);

    sst_pkg::t_key r_key;
    logic          r_valid;
    logic          r_gt;
    logic          r_ge;
    logic          r_eq;
    logic          r_sel;
    sst_pkg::t_key r_data;
    logic          pos_match;

    assign pos_match = (32'(i_index) == 32'(i_pos));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            r_valid <= r_valid | i_prev.valid;
        end else if (i_ctl.era) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_prev.p) begin
                r_key <= i_prev.key;
            end else if (o_link.p) begin
                r_key <= i_key;
            end
        end else if (i_ctl.era && r_ge) begin
            r_key <= i_next.key;
        end
    end

    // compare flags, refreshed every cycle from the held search key
    always_ff @(posedge i_clk) begin
        r_gt   <= r_valid && (i_key < r_key);
        r_ge   <= r_valid && (r_key >= i_key);
        r_eq   <= r_valid && (r_key == i_key);
        r_sel  <= r_valid && pos_match;
        r_data <= (r_valid && pos_match) ? r_key : '0;
    end

    assign o_link.key   = r_key;
    assign o_link.valid = r_valid;
    assign o_link.p     = r_gt | ~r_valid;
    assign o_link.ge    = r_ge;
    assign o_eq         = r_eq;
    assign o_sel        = r_sel;
    assign o_data       = r_data;

endmodule

`default_nettype wire

@@ sv/sst_reduce.sv @@
// Two-stage registered OR tree over the cell flags and read data.
// Uses sst_pkg.
`default_nettype none

module sst_reduce (
    input  wire                         i_clk,
    input  wire [sst_pkg::CAPACITY-1:0] i_eq,
    input  wire [sst_pkg::CAPACITY-1:0] i_sel,
    input  sst_pkg::t_key               i_data [sst_pkg::CAPACITY],
    output sst_pkg::t_red               o_red
);

    logic [sst_pkg::NGRP-1:0] r_grp_eq;
    logic [sst_pkg::NGRP-1:0] r_grp_sel;
    sst_pkg::t_key            r_grp_data [sst_pkg::NGRP];
    logic [sst_pkg::NGRP-1:0] n_grp_eq;
    logic [sst_pkg::NGRP-1:0] n_grp_sel;
    sst_pkg::t_key            n_grp_data [sst_pkg::NGRP];
    sst_pkg::t_red            r_red;
    sst_pkg::t_red            n_red;

    always_comb begin
        for (int g = 0; g < sst_pkg::NGRP; g++) begin
            n_grp_eq[g]   = 1'b0;
            n_grp_sel[g]  = 1'b0;
            n_grp_data[g] = '0;
            for (int m = 0; m < sst_pkg::GRP_SZ; m++) begin
                if (g * sst_pkg::GRP_SZ + m < sst_pkg::CAPACITY) begin
                    n_grp_eq[g]   = n_grp_eq[g] | i_eq[g * sst_pkg::GRP_SZ + m];
                    n_grp_sel[g]  = n_grp_sel[g] | i_sel[g * sst_pkg::GRP_SZ + m];
                    n_grp_data[g] = n_grp_data[g] | i_data[g * sst_pkg::GRP_SZ + m];
                end
            end
        end
    end

    always_comb begin
        n_red.found = |r_grp_eq;
        n_red.hit   = |r_grp_sel;
        n_red.data  = '0;
        for (int g = 0; g < sst_pkg::NGRP; g++) begin
            n_red.data = n_red.data | r_grp_data[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_eq   <= n_grp_eq;
        r_grp_sel  <= n_grp_sel;
        r_grp_data <= n_grp_data;
        r_red      <= n_red;
    end

    assign o_red = r_red;

endmodule

`default_nettype wire

@@ sv/sorted_set_table.sv @@
// Sorted set table: a chain of key cells, an OR reduce tree and the command
// sequencer. Depends on sst_pkg, sst_if, sst_cell and sst_reduce.
//
// Usage:
//   i_cmd carries one command item (insert, erase, contains, get by
//   position) with its key and position; o_res returns exactly one result
//   item per command: ok, read_key, count after the command and is_empty.
//   i_cmd.ready is high only while the sequencer is idle. An item is taken
//   at the edge where valid and ready are both high.
//   Every command steps through CMP, RED1, RED2 and APPLY: the cells register
//   their compares against the held key, the reduce tree needs two register
//   stages to merge the found/hit flags and the read data, then in APPLY the
//   cells shift and the result is registered at the same edge. A new command
//   is accepted only after the last one has left APPLY.
//   The result sits in an output register; the next command is accepted
//   while it waits. If o_res stays stalled, the following command holds in
//   its apply step until the output register frees, then the table updates.
//   Reset (synchronous, active low) empties the table at once: count goes
//   to zero and every cell is marked invalid; no clearing pass is needed.
`default_nettype none

module sorted_set_table (
    input  wire            i_clk,
    input  wire            i_rst_n,
    sst_cmd_if.sink        i_cmd,
    sst_res_if.source      o_res
);

    sst_pkg::t_state r_state;
    sst_pkg::t_state n_state;
    sst_pkg::t_cmd   r_cmd;
    sst_pkg::t_key   r_key;
    logic [7:0]      r_pos;
    sst_pkg::t_cnt   r_count;
    sst_pkg::t_cnt   n_count;
    sst_pkg::t_ctl   ctl;
    sst_pkg::t_red   red;

    logic            r_out_valid;
    logic            r_out_ok;
    logic [31:0]     r_out_key;
    logic            n_ok;
    logic            accept;
    logic            apply;
    logic            full;

    sst_pkg::t_link              links [sst_pkg::CAPACITY];
    sst_pkg::t_link              prev_links [sst_pkg::CAPACITY];
    sst_pkg::t_link              next_links [sst_pkg::CAPACITY];
    logic [sst_pkg::CAPACITY-1:0] eq;
    logic [sst_pkg::CAPACITY-1:0] sel;
    sst_pkg::t_key               data [sst_pkg::CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < sst_pkg::CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                // left edge: never shifts in, but lets slot 0 become valid
                assign prev_links[gi] = '{key: '0, valid: 1'b1, p: 1'b0, ge: 1'b0};
            end else begin : g_mid
                assign prev_links[gi] = links[gi-1];
            end
            if (gi == sst_pkg::CAPACITY - 1) begin : g_last
                assign next_links[gi] = '{key: '0, valid: 1'b0, p: 1'b1, ge: 1'b0};
            end else begin : g_body
                assign next_links[gi] = links[gi+1];
            end

            sst_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (sst_pkg::IDX_W'(gi)),
                .i_key   (r_key),
                .i_pos   (r_pos),
                .i_ctl   (ctl),
                .i_prev  (prev_links[gi]),
                .i_next  (next_links[gi]),
                .o_link  (links[gi]),
                .o_eq    (eq[gi]),
                .o_sel   (sel[gi]),
                .o_data  (data[gi])
            );
        end
    endgenerate

    sst_reduce u_reduce (
        .i_clk  (i_clk),
        .i_eq   (eq),
        .i_sel  (sel),
        .i_data (data),
        .o_red  (red)
    );

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign full        = (r_count == sst_pkg::CNT_W'(sst_pkg::CAPACITY));
    assign i_cmd.ready = (r_state == sst_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        apply   = 1'b0;
        ctl     = '{ins: 1'b0, era: 1'b0};
        n_count = r_count;
        n_ok    = 1'b0;
        unique case (r_state)
            sst_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = sst_pkg::ST_CMP;
                end
            end
            sst_pkg::ST_CMP:  n_state = sst_pkg::ST_RED1;
            sst_pkg::ST_RED1: n_state = sst_pkg::ST_RED2;
            sst_pkg::ST_RED2: n_state = sst_pkg::ST_APPLY;
            sst_pkg::ST_APPLY: begin
                // hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    apply   = 1'b1;
                    n_state = sst_pkg::ST_IDLE;
                end
            end
            default: n_state = sst_pkg::ST_IDLE;
        endcase

        unique case (r_cmd)
            sst_pkg::CMD_INSERT: begin
                n_ok    = !red.found && !full;
                ctl.ins = apply && n_ok;
                if (n_ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            sst_pkg::CMD_ERASE: begin
                n_ok    = red.found;
                ctl.era = apply && n_ok;
                if (n_ok) begin
                    n_count = r_count - 1'b1;
                end
            end
            sst_pkg::CMD_CONTAINS: n_ok = red.found;
            sst_pkg::CMD_GET:      n_ok = red.hit;
            default:               n_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sst_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd.command;
            r_key <= sst_pkg::KEY_BITS'(i_cmd.key);
            r_pos <= i_cmd.position;
        end
        if (apply) begin
            r_out_ok  <= n_ok;
            r_out_key <= (r_cmd == sst_pkg::CMD_GET && red.hit) ? 32'(red.data) : '0;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.ok       = r_out_ok;
    assign o_res.read_key = r_out_key;
    assign o_res.count    = 9'(r_count);
    assign o_res.is_empty = (r_count == '0);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
        else $error("count above capacity");

    a_ins_era_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.ins && ctl.era))
        else $error("insert and erase strobes together");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not raise count");

    a_era_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.era |=> r_count == $past(r_count) - 1'b1)
        else $error("erase did not lower count");

    a_apply_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply |=> r_out_valid && r_state == sst_pkg::ST_IDLE)
        else $error("apply step left no result");

endmodule

`default_nettype wire
